// ----- hdl/eye_midpoint_head_pose_macros.svh -----
// assertion macros for the eye midpoint head pose block
`ifndef EYE_MIDPOINT_HEAD_POSE_MACROS_SVH
`define EYE_MIDPOINT_HEAD_POSE_MACROS_SVH
// implication checked at every edge out of reset
`define EMHP_ASSERT_IMP(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error("assertion failed");
// next-cycle implication
`define EMHP_ASSERT_NEXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error("assertion failed");
`endif

// ----- hdl/emhp_pkg.sv -----
// ----------------------------------------------------------------------------
// emhp_pkg
// shared constants, types and tables of the eye midpoint head pose block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package emhp_pkg;
    localparam int CoordW = 17;
    localparam int ShiftW = 19;
    localparam int AngW = 17;
    localparam int CordicSteps = 23;
    localparam int StepW = 5;
    localparam int DivSteps = 32;
    localparam int DivCntW = 6;
    localparam int Deg180 = 46080;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic cordic_init;
        logic cordic_step;
        logic cordic_sel;
        logic cordic_save;
        logic div_init;
        logic div_step;
        logic finish;
    } emhp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic both;
        logic need_pitch;
    } emhp_sts_t;

    function automatic logic [21:0] atan_q16(input logic [StepW-1:0] i);
        logic [21:0] r;
        case (i)
            5'd0: r = 22'd2949120; 5'd1: r = 22'd1740967; 5'd2: r = 22'd919879;
            5'd3: r = 22'd466945;  5'd4: r = 22'd234379;  5'd5: r = 22'd117304;
            5'd6: r = 22'd58666;   5'd7: r = 22'd29335;   5'd8: r = 22'd14668;
            5'd9: r = 22'd7334;    5'd10: r = 22'd3667;   5'd11: r = 22'd1833;
            5'd12: r = 22'd917;    5'd13: r = 22'd458;    5'd14: r = 22'd229;
            5'd15: r = 22'd115;    5'd16: r = 22'd57;     5'd17: r = 22'd29;
            5'd18: r = 22'd14;     5'd19: r = 22'd7;      5'd20: r = 22'd4;
            5'd21: r = 22'd2;      5'd22: r = 22'd1;
            default: r = 22'd0;
        endcase
        return r;
    endfunction
endpackage

// ----- hdl/emhp_ctrl.sv -----
// ----------------------------------------------------------------------------
// emhp_ctrl
// sequencer: load, two cordic passes, pitch divide (each as needed), hand-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "eye_midpoint_head_pose_macros.svh"
module emhp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                in_any,
    output logic                s_ready,
    input  logic                m_valid,
    input  logic                m_ready,
    input  emhp_pkg::emhp_sts_t sts,
    output emhp_pkg::emhp_cmd_t cmd
);
    import emhp_pkg::*;

    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StPrep = 3'd1;
    localparam logic [2:0] StCord = 3'd2;
    localparam logic [2:0] StDiv  = 3'd3;
    localparam logic [2:0] StDone = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [DivCntW-1:0] cnt_reg, cnt_next;
    logic pass_reg, pass_next;

    // accept only when idle and the output slot is free or draining
    assign s_ready = (state_reg == StIdle) && (!m_valid || m_ready);

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        pass_next = pass_reg;
        cmd = '0;
        case (state_reg)
            StIdle: begin
                if (s_valid && s_ready && in_any) begin
                    cmd.load = 1'b1;
                    state_next = StPrep;
                    pass_next = 1'b0;
                end
            end
            StPrep: begin
                if (sts.both) begin
                    cmd.cordic_init = 1'b1;
                    cmd.cordic_sel = pass_reg;
                    cnt_next = '0;
                    state_next = StCord;
                end else begin
                    state_next = StDone;
                end
            end
            StCord: begin
                cmd.cordic_sel = pass_reg;
                if (cnt_reg == DivCntW'(CordicSteps)) begin
                    cmd.cordic_save = 1'b1;
                    if (!pass_reg) begin
                        pass_next = 1'b1;
                        state_next = StPrep;
                    end else if (sts.need_pitch) begin
                        cmd.div_init = 1'b1;
                        cnt_next = '0;
                        state_next = StDiv;
                    end else begin
                        state_next = StDone;
                    end
                end else begin
                    cmd.cordic_step = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            StDiv: begin
                if (cnt_reg == DivCntW'(DivSteps)) begin
                    state_next = StDone;
                end else begin
                    cmd.div_step = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            StDone: begin
                cmd.finish = 1'b1;
                state_next = StIdle;
            end
            default: state_next = StIdle;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= StIdle;
            cnt_reg <= '0;
            pass_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            pass_reg <= pass_next;
        end
    end

    `EMHP_ASSERT_IMP(a_ready_idle, aclk, aresetn, s_ready, state_reg == StIdle)
    `EMHP_ASSERT_NEXT(a_load_prep, aclk, aresetn, cmd.load, state_reg == StPrep)
    `EMHP_ASSERT_IMP(a_cord_cnt, aclk, aresetn, state_reg == StCord,
        cnt_reg <= DivCntW'(CordicSteps))
endmodule

// ----- hdl/emhp_dp.sv -----
// ----------------------------------------------------------------------------
// emhp_dp
// datapath: midpoint, baseline, shared cordic, restoring divider, output item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module emhp_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  emhp_pkg::emhp_cmd_t cmd,
    output emhp_pkg::emhp_sts_t sts,
    input  logic                lv,
    input  logic signed [emhp_pkg::CoordW-1:0] lx, ly, lz,
    input  logic                rv,
    input  logic signed [emhp_pkg::CoordW-1:0] rx, ry, rz,
    input  logic                m_ready,
    output logic                m_valid,
    output logic signed [emhp_pkg::ShiftW-1:0] o_sx, o_sy, o_sz,
    output logic                o_av,
    output logic signed [emhp_pkg::AngW-1:0] o_yaw, o_roll,
    output logic                o_pv,
    output logic signed [emhp_pkg::AngW-1:0] o_pitch
);
    import emhp_pkg::*;

    logic signed [CoordW-1:0] mx_reg, my_reg, mz_reg;
    logic signed [CoordW:0] dx_reg, dy_reg, dz_reg;
    logic both_reg;
    logic signed [CoordW-1:0] bx_reg, by_reg, bz_reg;
    logic cap_reg;

    // midpoint or single eye
    logic signed [CoordW:0] sx, sy, sz;
    assign sx = 18'(lx) + 18'(rx);
    assign sy = 18'(ly) + 18'(ry);
    assign sz = 18'(lz) + 18'(rz);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            both_reg <= lv && rv;
            dx_reg <= 18'(rx) - 18'(lx);
            dy_reg <= 18'(ry) - 18'(ly);
            dz_reg <= 18'(rz) - 18'(lz);
            if (lv && rv) begin
                mx_reg <= sx[CoordW:1]; my_reg <= sy[CoordW:1]; mz_reg <= sz[CoordW:1];
            end else if (lv) begin
                mx_reg <= lx; my_reg <= ly; mz_reg <= lz;
            end else begin
                mx_reg <= rx; my_reg <= ry; mz_reg <= rz;
            end
        end
    end

    // baseline latched on first binocular frame
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bx_reg <= '0; by_reg <= '0; bz_reg <= '0; cap_reg <= 1'b0;
        end else if (cmd.load && lv && rv && !cap_reg) begin
            bx_reg <= sx[CoordW:1]; by_reg <= sy[CoordW:1]; bz_reg <= sz[CoordW:1];
            cap_reg <= 1'b1;
        end
    end

    assign sts.both = both_reg;
    assign sts.need_pitch = (bz_reg > 17'sd16);

    // cordic, 34-bit vectors (inputs x4096 keep within 31 bits with growth)
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [24:0] cz_reg;
    logic signed [AngW:0] cbase_reg;
    logic [1:0] cspec_reg;        // 0 normal, 1 fixed result
    logic signed [AngW:0] cfix_reg;
    logic [StepW-1:0] ci_reg;
    logic signed [AngW-1:0] yaw_reg, roll_reg;

    logic signed [CoordW:0] ay;
    assign ay = cmd.cordic_sel ? dy_reg : dz_reg;

    logic signed [24:0] zr;
    logic signed [AngW+1:0] rr;
    logic signed [AngW-1:0] rclamp;
    always_comb begin
        zr = cz_reg + 25'sd128;
        if (cspec_reg != 2'd0) rr = 19'(cfix_reg);
        else rr = 19'(cbase_reg) + 19'(zr >>> 8);
        if (rr > 19'sd46080) rclamp = 17'sd46080;
        else if (rr < -19'sd46080) rclamp = -17'sd46080;
        else rclamp = rr[AngW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.cordic_init) begin
            ci_reg <= '0;
            cz_reg <= '0;
            // exact axes, left half-plane fold, or plain vectoring
            if (ay == 0) begin
                cspec_reg <= 2'd1;
                cfix_reg <= (dx_reg >= 0) ? 18'sd0 : 18'sd46080;
                cbase_reg <= '0;
            end else if (dx_reg == 0) begin
                cspec_reg <= 2'd1;
                cfix_reg <= (ay > 0) ? 18'sd23040 : -18'sd23040;
                cbase_reg <= '0;
            end else if (dx_reg < 0) begin
                cspec_reg <= 2'd0;
                cfix_reg <= '0;
                cbase_reg <= (ay > 0) ? 18'sd46080 : -18'sd46080;
            end else begin
                cspec_reg <= 2'd0;
                cfix_reg <= '0;
                cbase_reg <= '0;
            end
            // start vector, mirrored through the origin in the left half-plane
            if (ay != 0 && dx_reg < 0) begin
                cx_reg <= -(34'(dx_reg) <<< 12);
                cy_reg <= -(34'(ay) <<< 12);
            end else begin
                cx_reg <= 34'(dx_reg) <<< 12;
                cy_reg <= 34'(ay) <<< 12;
            end
        end else if (cmd.cordic_step) begin
            ci_reg <= ci_reg + 1'b1;
            if (cy_reg > 0) begin
                cx_reg <= cx_reg + (cy_reg >>> ci_reg);
                cy_reg <= cy_reg - (cx_reg >>> ci_reg);
                cz_reg <= cz_reg + 25'(atan_q16(ci_reg));
            end else begin
                cx_reg <= cx_reg - (cy_reg >>> ci_reg);
                cy_reg <= cy_reg + (cx_reg >>> ci_reg);
                cz_reg <= cz_reg - 25'(atan_q16(ci_reg));
            end
        end
        if (cmd.cordic_save) begin
            if (cmd.cordic_sel) roll_reg <= rclamp;
            else yaw_reg <= -rclamp;
        end
    end

    // pitch: (2n + bz) / (2 bz), restoring, one quotient bit a cycle
    // the 32-bit numerator sits at the top of the 34-bit shift register
    logic [33:0] num_reg;
    logic [33:0] rem_reg;
    logic [31:0] quo_reg;
    logic [17:0] den_reg;
    logic neg_reg;
    logic signed [CoordW:0] dm;
    logic [CoordW:0] adm;
    logic [33:0] rtry;
    assign dm = 18'(mz_reg) - 18'(bz_reg);
    assign adm = dm[CoordW] ? 18'(-dm) : 18'(dm);
    assign rtry = {rem_reg[32:0], num_reg[33]} - 34'(den_reg);

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            num_reg <= ((34'(adm) * 34'd30720) + 34'(bz_reg)) << 2;
            den_reg <= {bz_reg, 1'b0};
            rem_reg <= '0;
            quo_reg <= '0;
            neg_reg <= dm[CoordW];
        end else if (cmd.div_step) begin
            num_reg <= {num_reg[32:0], 1'b0};
            if (!rtry[33]) begin
                rem_reg <= rtry;
                quo_reg <= {quo_reg[30:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[32:0], num_reg[33]};
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

    logic signed [AngW-1:0] pq;
    assign pq = (quo_reg > 32'd46080) ? 17'sd46080 : 17'(quo_reg);

    // cm q8 conversion: round(|d|*16/10)
    function automatic logic signed [ShiftW-1:0] to_cm(input logic signed [CoordW:0] d);
        logic [CoordW:0] m;
        logic [23:0] t;
        logic [47:0] p;
        logic [ShiftW-1:0] q;
        m = d[CoordW] ? 18'(-d) : 18'(d);
        t = 24'(m) * 24'd8 + 24'd2;
        // divide by 5: multiply by ceil(2^23 / 5), exact for t below 2^22
        p = 48'(t) * 48'd1677722;
        q = ShiftW'(p >> 23);
        return d[CoordW] ? -$signed(q) : $signed(q);
    endfunction

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (cmd.finish) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            o_sx <= -to_cm(18'(mx_reg) - 18'(bx_reg));
            o_sy <= to_cm(18'(my_reg) - 18'(by_reg));
            o_sz <= to_cm(dm);
            o_av <= both_reg;
            o_yaw <= both_reg ? yaw_reg : '0;
            o_roll <= both_reg ? roll_reg : '0;
            o_pv <= both_reg && sts.need_pitch;
            o_pitch <= (both_reg && sts.need_pitch) ? (neg_reg ? pq : -pq) : '0;
        end
    end
endmodule

// ----- hdl/eye_midpoint_head_pose.sv -----
// ----------------------------------------------------------------------------
// eye_midpoint_head_pose
// head translation and angles from one binocular eye-position frame
// ----------------------------------------------------------------------------
// a single-eye frame goes straight to the result; both eyes run one cordic unit
// twice for 23 steps each, then, when pitch is needed, a 32-step restoring divider
// a new frame is taken only once the last is done and the output slot is free or
// draining; frames with no valid eye are consumed with no result
// reset clears the baseline, its capture flag and the result valid
`timescale 1ns / 1ps
module eye_midpoint_head_pose (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  logic s_left_valid,
    input  logic signed [emhp_pkg::CoordW-1:0] s_left_x, s_left_y, s_left_z,
    input  logic s_right_valid,
    input  logic signed [emhp_pkg::CoordW-1:0] s_right_x, s_right_y, s_right_z,
    output logic m_valid,
    input  logic m_ready,
    output logic signed [emhp_pkg::ShiftW-1:0] m_shift_x, m_shift_y, m_shift_z,
    output logic m_angles_valid,
    output logic signed [emhp_pkg::AngW-1:0] m_yaw_angle, m_roll_angle,
    output logic m_pitch_valid,
    output logic signed [emhp_pkg::AngW-1:0] m_pitch_angle
);
    import emhp_pkg::*;

    emhp_cmd_t cmd;
    emhp_sts_t sts;

    emhp_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid),
        .in_any(s_left_valid || s_right_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .sts(sts), .cmd(cmd)
    );

    emhp_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .lv(s_left_valid), .lx(s_left_x), .ly(s_left_y), .lz(s_left_z),
        .rv(s_right_valid), .rx(s_right_x), .ry(s_right_y), .rz(s_right_z),
        .m_ready(m_ready), .m_valid(m_valid),
        .o_sx(m_shift_x), .o_sy(m_shift_y), .o_sz(m_shift_z),
        .o_av(m_angles_valid), .o_yaw(m_yaw_angle), .o_roll(m_roll_angle),
        .o_pv(m_pitch_valid), .o_pitch(m_pitch_angle)
    );
endmodule
